[rtl/core/slf_pkg.sv]
`default_nettype none
package slf_pkg;

  localparam int MAX_FRAC_DIGITS = 9;
  localparam int FRAC_CAP = (MAX_FRAC_DIGITS < 9) ? MAX_FRAC_DIGITS : 9;

  localparam int MQ_DEPTH = 2;
  localparam int MQ_AW = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = $clog2(OQ_DEPTH);
  localparam int ROWS_MAX = 3;

  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_F       = 8'h66;

  typedef enum logic [2:0] {
    TK_OPEN  = 3'd0,
    TK_CLOSE = 3'd1,
    TK_INT   = 3'd2,
    TK_DEC   = 3'd3,
    TK_BOOL  = 3'd4,
    TK_STR   = 3'd5,
    TK_SYM   = 3'd6,
    TK_ERR   = 3'd7
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_START = 2'd1,
    ERR_BAD_BOOL = 2'd2,
    ERR_OPEN_STR = 2'd3
  } err_code_t;

  typedef enum logic [2:0] {
    LM_IDLE,
    LM_COMMENT,
    LM_SIGN,
    LM_INT,
    LM_FRAC,
    LM_HASH,
    LM_STRING,
    LM_SYMBOL
  } lex_mode_t;

  typedef enum logic [3:0] {
    CC_SPACE,
    CC_NEWLINE,
    CC_SEMI,
    CC_OPEN,
    CC_CLOSE,
    CC_PLUS,
    CC_MINUS,
    CC_DIGIT,
    CC_HASH,
    CC_QUOTE,
    CC_DOT,
    CC_INITIAL,
    CC_OTHER
  } chr_class_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic [7:0]         text_byte;
    logic               text_valid;
    logic               last;
    logic signed [31:0] int_value;
    logic [29:0]        frac_value;
    logic [3:0]         frac_digits;
    logic               bool_value;
    err_code_t          error_code;
  } out_word_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       eoi;
    chr_class_t cls;
  } mid_word_t;

  function automatic logic [29:0] pow_ten(input logic [3:0] n);
    logic [29:0] p;
    unique case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[rtl/core/slf_front.sv]
`default_nettype none
module slf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  slf_pkg::in_word_t   in_word,
  output logic                full,
  output logic                mid_valid,
  output slf_pkg::mid_word_t  mid_word,
  input  logic                mid_pop
);
  import slf_pkg::*;

  mid_word_t        q_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wr_r, wr_nxt;
  logic [MQ_AW-1:0] rd_r, rd_nxt;
  logic [MQ_AW:0]   cnt_r, cnt_nxt;
  logic             push_fire;
  mid_word_t        cls_word;

  // character class lookup
  always_comb begin
    cls_word.chr = in_word.in_byte;
    cls_word.eoi = in_word.end_of_input;
    unique case (in_word.in_byte) inside
      CH_SPACE:                  cls_word.cls = CC_SPACE;
      CH_NEWLINE:                cls_word.cls = CC_NEWLINE;
      CH_SEMI:                   cls_word.cls = CC_SEMI;
      CH_OPEN:                   cls_word.cls = CC_OPEN;
      CH_CLOSE:                  cls_word.cls = CC_CLOSE;
      CH_PLUS:                   cls_word.cls = CC_PLUS;
      CH_MINUS:                  cls_word.cls = CC_MINUS;
      CH_HASH:                   cls_word.cls = CC_HASH;
      CH_QUOTE:                  cls_word.cls = CC_QUOTE;
      CH_DOT:                    cls_word.cls = CC_DOT;
      [8'h30:8'h39]:             cls_word.cls = CC_DIGIT;
      [8'h41:8'h5A], [8'h61:8'h7A],
      8'h21, 8'h24, 8'h26, 8'h2A, 8'h2F, 8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
      8'h5E, 8'h5F:              cls_word.cls = CC_INITIAL;
      default:                   cls_word.cls = CC_OTHER;
    endcase
  end

  assign full      = (cnt_r == (MQ_AW+1)'(MQ_DEPTH));
  assign push_fire = push && !full;
  assign mid_valid = (cnt_r != '0);
  assign mid_word  = q_r[rd_r];

  always_comb begin
    wr_nxt  = push_fire ? wr_r + MQ_AW'(1) : wr_r;
    rd_nxt  = mid_pop ? rd_r + MQ_AW'(1) : rd_r;
    cnt_nxt = cnt_r + (MQ_AW+1)'(push_fire) - (MQ_AW+1)'(mid_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_r[wr_r] <= cls_word;
    end
  end

endmodule
`default_nettype wire

[rtl/core/slf_back.sv]
`default_nettype none
module slf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mid_valid,
  input  slf_pkg::mid_word_t  mid_word,
  output logic                mid_pop,
  input  logic                pop,
  output logic                empty,
  output slf_pkg::out_word_t  out_word
);
  import slf_pkg::*;

  lex_mode_t        mode_r, mode_nxt;
  logic             neg_r, neg_nxt;
  logic             psign_r, psign_nxt;
  logic [31:0]      iacc_r, iacc_nxt;
  logic [29:0]      facc_r, facc_nxt;
  logic [3:0]       fcnt_r, fcnt_nxt;
  logic             halt_r, halt_nxt;

  out_word_t        rows_c [ROWS_MAX];
  logic [1:0]       nrow_c;
  logic             relex_c;
  logic             err_c;
  out_word_t        num_row_c;
  logic [7:0]       sign_chr;
  logic             is_subseq;
  logic [3:0]       dval;

  out_word_t        oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] owr_r, ord_r;
  logic [OQ_AW:0]   ocnt_r;
  logic             pop_fire;
  logic             room;

  function automatic out_word_t mk_end(input tok_kind_t k);
    out_word_t r;
    r      = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_word_t mk_text(input tok_kind_t k, input logic [7:0] c,
                                        input logic lst);
    out_word_t r;
    r            = '0;
    r.kind       = k;
    r.text_byte  = c;
    r.text_valid = 1'b1;
    r.last       = lst;
    return r;
  endfunction

  function automatic out_word_t mk_err(input err_code_t e);
    out_word_t r;
    r            = '0;
    r.kind       = TK_ERR;
    r.last       = 1'b1;
    r.error_code = e;
    return r;
  endfunction

  assign sign_chr  = psign_r ? CH_MINUS : CH_PLUS;
  assign dval      = mid_word.chr[3:0];
  assign is_subseq = (mid_word.cls == CC_INITIAL) || (mid_word.cls == CC_DIGIT) ||
                     (mid_word.cls == CC_PLUS) || (mid_word.cls == CC_MINUS) ||
                     (mid_word.cls == CC_DOT);

  // pending number flushed as one word; a negative decimal is shown as floor plus fraction
  always_comb begin
    num_row_c      = '0;
    num_row_c.last = 1'b1;
    if (mode_r == LM_FRAC) begin
      num_row_c.kind        = TK_DEC;
      num_row_c.frac_digits = fcnt_r;
      if (neg_r && (facc_r != '0)) begin
        num_row_c.int_value  = ~iacc_r;
        num_row_c.frac_value = pow_ten(fcnt_r) - facc_r;
      end else begin
        num_row_c.int_value  = neg_r ? (32'd0 - iacc_r) : iacc_r;
        num_row_c.frac_value = facc_r;
      end
    end else begin
      num_row_c.kind      = TK_INT;
      num_row_c.int_value = neg_r ? (32'd0 - iacc_r) : iacc_r;
    end
  end

  // lexer next state and result words for one character
  always_comb begin
    for (int i = 0; i < ROWS_MAX; i++) begin
      rows_c[i] = '0;
    end
    nrow_c    = '0;
    relex_c   = 1'b0;
    err_c     = 1'b0;
    mode_nxt  = mode_r;
    neg_nxt   = neg_r;
    psign_nxt = psign_r;
    iacc_nxt  = iacc_r;
    facc_nxt  = facc_r;
    fcnt_nxt  = fcnt_r;

    if (mid_word.eoi) begin
      unique case (mode_r)
        LM_SIGN: begin
          rows_c[0] = mk_text(TK_SYM, sign_chr, 1'b0);
          rows_c[1] = mk_end(TK_SYM);
          nrow_c    = 2'd2;
        end
        LM_INT, LM_FRAC: begin
          rows_c[0] = num_row_c;
          nrow_c    = 2'd1;
        end
        LM_HASH: begin
          rows_c[0] = mk_err(ERR_BAD_BOOL);
          nrow_c    = 2'd1;
          err_c     = 1'b1;
        end
        LM_STRING: begin
          rows_c[0] = mk_err(ERR_OPEN_STR);
          nrow_c    = 2'd1;
          err_c     = 1'b1;
        end
        LM_SYMBOL: begin
          rows_c[0] = mk_end(TK_SYM);
          nrow_c    = 2'd1;
        end
        default: begin
        end
      endcase
      mode_nxt = LM_IDLE;
    end else begin
      unique case (mode_r)
        LM_COMMENT: begin
          if (mid_word.cls == CC_NEWLINE) begin
            mode_nxt = LM_IDLE;
          end
        end
        LM_SIGN: begin
          if (mid_word.cls == CC_DIGIT) begin
            neg_nxt  = psign_r;
            iacc_nxt = 32'(dval);
            mode_nxt = LM_INT;
          end else begin
            rows_c[0] = mk_text(TK_SYM, sign_chr, 1'b0);
            if (is_subseq) begin
              rows_c[1] = mk_text(TK_SYM, mid_word.chr, 1'b0);
              nrow_c    = 2'd2;
              mode_nxt  = LM_SYMBOL;
            end else begin
              rows_c[1] = mk_end(TK_SYM);
              nrow_c    = 2'd2;
              relex_c   = 1'b1;
            end
          end
        end
        LM_INT: begin
          if (mid_word.cls == CC_DIGIT) begin
            iacc_nxt = (iacc_r << 3) + (iacc_r << 1) + 32'(dval);
          end else if (mid_word.cls == CC_DOT) begin
            facc_nxt = '0;
            fcnt_nxt = '0;
            mode_nxt = LM_FRAC;
          end else begin
            rows_c[0] = num_row_c;
            nrow_c    = 2'd1;
            relex_c   = 1'b1;
          end
        end
        LM_FRAC: begin
          if (mid_word.cls == CC_DIGIT) begin
            if (fcnt_r < 4'(FRAC_CAP)) begin
              facc_nxt = (facc_r << 3) + (facc_r << 1) + 30'(dval);
              fcnt_nxt = fcnt_r + 4'd1;
            end
          end else begin
            rows_c[0] = num_row_c;
            nrow_c    = 2'd1;
            relex_c   = 1'b1;
          end
        end
        LM_HASH: begin
          if ((mid_word.chr == CH_T) || (mid_word.chr == CH_F)) begin
            rows_c[0]            = mk_end(TK_BOOL);
            rows_c[0].bool_value = (mid_word.chr == CH_T);
            nrow_c               = 2'd1;
            mode_nxt             = LM_IDLE;
          end else begin
            rows_c[0] = mk_err(ERR_BAD_BOOL);
            nrow_c    = 2'd1;
            err_c     = 1'b1;
          end
        end
        LM_STRING: begin
          rows_c[0] = mk_text(TK_STR, mid_word.chr, mid_word.cls == CC_QUOTE);
          nrow_c    = 2'd1;
          if (mid_word.cls == CC_QUOTE) begin
            mode_nxt = LM_IDLE;
          end
        end
        LM_SYMBOL: begin
          if (is_subseq) begin
            rows_c[0] = mk_text(TK_SYM, mid_word.chr, 1'b0);
            nrow_c    = 2'd1;
          end else begin
            rows_c[0] = mk_end(TK_SYM);
            nrow_c    = 2'd1;
            relex_c   = 1'b1;
          end
        end
        default: begin
          relex_c = 1'b1;
        end
      endcase

      // character taken as the start of a new token
      if (relex_c) begin
        mode_nxt = LM_IDLE;
        unique case (mid_word.cls)
          CC_SEMI: mode_nxt = LM_COMMENT;
          CC_OPEN: begin
            rows_c[nrow_c] = mk_end(TK_OPEN);
            nrow_c         = nrow_c + 2'd1;
          end
          CC_CLOSE: begin
            rows_c[nrow_c] = mk_end(TK_CLOSE);
            nrow_c         = nrow_c + 2'd1;
          end
          CC_PLUS, CC_MINUS: begin
            psign_nxt = (mid_word.cls == CC_MINUS);
            mode_nxt  = LM_SIGN;
          end
          CC_DIGIT: begin
            neg_nxt  = 1'b0;
            iacc_nxt = 32'(dval);
            mode_nxt = LM_INT;
          end
          CC_HASH: mode_nxt = LM_HASH;
          CC_QUOTE: begin
            rows_c[nrow_c] = mk_text(TK_STR, mid_word.chr, 1'b0);
            nrow_c         = nrow_c + 2'd1;
            mode_nxt       = LM_STRING;
          end
          CC_INITIAL: begin
            rows_c[nrow_c] = mk_text(TK_SYM, mid_word.chr, 1'b0);
            nrow_c         = nrow_c + 2'd1;
            mode_nxt       = LM_SYMBOL;
          end
          CC_SPACE, CC_NEWLINE: begin
          end
          default: begin
            rows_c[nrow_c] = mk_err(ERR_BAD_START);
            nrow_c         = nrow_c + 2'd1;
            err_c          = 1'b1;
          end
        endcase
      end
    end

    halt_nxt = halt_r || err_c;
    if (err_c) begin
      mode_nxt = LM_IDLE;
    end

    // once halted every word is dropped
    if (halt_r) begin
      nrow_c    = '0;
      mode_nxt  = mode_r;
      neg_nxt   = neg_r;
      psign_nxt = psign_r;
      iacc_nxt  = iacc_r;
      facc_nxt  = facc_r;
      fcnt_nxt  = fcnt_r;
    end
  end

  // take a word only when the result queue can hold three more
  assign pop_fire = pop && !empty;
  assign room     = (ocnt_r <= (OQ_AW+1)'(OQ_DEPTH - ROWS_MAX)) ||
                    (pop_fire && (ocnt_r <= (OQ_AW+1)'(OQ_DEPTH - ROWS_MAX + 1)));
  assign mid_pop  = mid_valid && room;
  assign empty    = (ocnt_r == '0);
  assign out_word = oq_r[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= LM_IDLE;
      neg_r   <= 1'b0;
      psign_r <= 1'b0;
      iacc_r  <= '0;
      facc_r  <= '0;
      fcnt_r  <= '0;
      halt_r  <= 1'b0;
    end else if (mid_pop) begin
      mode_r  <= mode_nxt;
      neg_r   <= neg_nxt;
      psign_r <= psign_nxt;
      iacc_r  <= iacc_nxt;
      facc_r  <= facc_nxt;
      fcnt_r  <= fcnt_nxt;
      halt_r  <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (mid_pop) begin
        owr_r <= owr_r + OQ_AW'(nrow_c);
      end
      if (pop_fire) begin
        ord_r <= ord_r + OQ_AW'(1);
      end
      ocnt_r <= ocnt_r + (mid_pop ? (OQ_AW+1)'(nrow_c) : '0) - (OQ_AW+1)'(pop_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      for (int i = 0; i < ROWS_MAX; i++) begin
        if (2'(i) < nrow_c) begin
          oq_r[owr_r + OQ_AW'(i)] <= rows_c[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/scheme_token_lexer_unit.sv]
// a pushed byte is registered in the classifier queue, then its words in the result queue
// throughput: one byte per cycle, bounded by the result side, which moves one word per pop;
//   a byte yields zero to three words, set by the lexer writing its words into a 4-entry queue
// a 2-entry queue between classifier and lexer keeps push open while results wait
// reset: synchronous active-low rst_n empties both queues and returns the lexer to idle,
//   clearing its halted state
`default_nettype none
module scheme_token_lexer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  slf_pkg::in_word_t   in_word,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output slf_pkg::out_word_t  out_word
);
  import slf_pkg::*;

  logic      mid_valid;
  logic      mid_pop;
  mid_word_t mid_word;

  slf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_word   (in_word),
    .full      (full),
    .mid_valid (mid_valid),
    .mid_word  (mid_word),
    .mid_pop   (mid_pop)
  );

  slf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_word  (mid_word),
    .mid_pop   (mid_pop),
    .pop       (pop),
    .empty     (empty),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
